### hw/rtl/atqe_pkg.sv
`default_nettype none
package atqe_pkg;
    localparam int unsigned QueueDepthDef = 16;
    localparam int unsigned NumTopicsDef  = 4;

    localparam logic [1:0] ActPublish = 2'd0;
    localparam logic [1:0] ActGet     = 2'd1;
    localparam logic [1:0] ActClean   = 2'd2;
    localparam logic [1:0] ActNone    = 2'd3;

    localparam logic [1:0] StFail = 2'd0;
    localparam logic [1:0] StOk   = 2'd1;
    localparam logic [1:0] StSkip = 2'd2;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_READ,
        CMD_WRITE,
        CMD_POP,
        CMD_OUT_ENTRY,
        CMD_OUT_ZERO,
        CMD_OUT_CLEAN
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [1:0] status;
        logic       read_next;
        logic       step;
    } t_ctl;

    typedef struct packed {
        logic bad;
        logic empty;
        logic full;
        logic last_zero;
        logic match;
        logic at_end;
        logic older;
        logic aged;
    } t_sts;
endpackage
`default_nettype wire

### hw/rtl/atqe_ctrl.sv
`default_nettype none
module atqe_ctrl
    import atqe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [1:0] i_action,
    input  wire t_sts       i_sts,
    output logic            o_busy,
    output logic            o_skip,
    output t_ctl            o_ctl
);
    typedef enum logic [2:0] {S_IDLE, S_DEC, S_GRD, S_GCHK, S_CRD, S_CCHK, S_OUT} t_state;

    t_state     r_state;
    logic [1:0] r_act;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        o_ctl = '{cmd: CMD_NONE, status: StFail, read_next: 1'b0, step: 1'b0};
        unique case (r_state)
            S_IDLE: if (i_start) o_ctl.cmd = CMD_LOAD;
            S_DEC: begin
                if (i_sts.bad) o_ctl.cmd = CMD_OUT_ZERO;
                else if (r_act == ActPublish) begin
                    if (i_sts.full) o_ctl.cmd = CMD_OUT_ZERO;
                    else o_ctl.cmd = CMD_WRITE;
                end else if (r_act == ActGet) begin
                    if (i_sts.empty || i_sts.last_zero) o_ctl.cmd = CMD_OUT_ZERO;
                    else o_ctl.cmd = CMD_READ;
                end else begin
                    if (i_sts.empty) o_ctl.cmd = CMD_OUT_ZERO;
                    else o_ctl.cmd = CMD_READ;
                end
            end
            S_GCHK: begin
                if (i_sts.match) begin
                    if (i_sts.at_end) o_ctl.cmd = CMD_OUT_ZERO;
                    else begin
                        o_ctl.cmd = CMD_READ;
                        o_ctl.read_next = 1'b1;
                    end
                end else if (i_sts.at_end) begin
                    if (i_sts.older) begin
                        o_ctl.cmd = CMD_READ;
                        o_ctl.read_next = 1'b1;
                    end else o_ctl.cmd = CMD_OUT_ZERO;
                end else begin
                    o_ctl.cmd = CMD_READ;
                    o_ctl.step = 1'b1;
                end
            end
            S_CCHK: begin
                if (i_sts.aged && !i_sts.empty) o_ctl.cmd = CMD_POP;
                else o_ctl.cmd = CMD_OUT_CLEAN;
            end
            S_OUT: o_ctl.cmd = CMD_OUT_ENTRY;
            default: o_ctl.cmd = CMD_NONE;
        endcase
    end

    logic r_fin;
    logic r_skip;

    assign o_skip = r_skip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_act   <= ActPublish;
            r_fin   <= 1'b0;
            r_skip  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    r_act   <= i_action;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_skip <= 1'b0;
                    r_fin  <= 1'b0;
                    priority case (o_ctl.cmd)
                        CMD_WRITE: r_state <= S_IDLE;
                        CMD_READ:  r_state <= (r_act == ActGet) ? S_GRD : S_CRD;
                        default:   r_state <= S_IDLE;
                    endcase
                end
                S_GRD: r_state <= r_fin ? S_OUT : S_GCHK;
                S_GCHK: begin
                    if (o_ctl.cmd == CMD_OUT_ZERO) r_state <= S_IDLE;
                    else begin
                        if (o_ctl.read_next) begin
                            r_fin  <= 1'b1;
                            r_skip <= !i_sts.match;
                        end
                        r_state <= S_GRD;
                    end
                end
                S_CRD: r_state <= S_CCHK;
                S_CCHK: r_state <= (o_ctl.cmd == CMD_POP) ? S_CRD : S_IDLE;
                S_OUT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### hw/rtl/atqe_dp.sv
`default_nettype none
module atqe_dp
    import atqe_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
    parameter int unsigned NUM_TOPICS  = NumTopicsDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_ctl        i_ctl,
    input  wire logic        i_skip,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic [1:0]  i_action,
    input  wire logic [1:0]  i_topic,
    input  wire logic [7:0]  i_publisher_id,
    input  wire logic [31:0] i_payload_handle,
    input  wire logic [31:0] i_last_entry,
    input  wire logic [31:0] i_now_seconds,
    output t_sts             o_sts,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [31:0]      o_entry_number,
    output logic [7:0]       o_entry_publisher,
    output logic [31:0]      o_entry_payload,
    output logic [31:0]      o_entry_stamp,
    output logic [4:0]       o_removed_count
);
    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned TW = (NUM_TOPICS > 1) ? $clog2(NUM_TOPICS) : 1;
    localparam int unsigned SLOTS = NUM_TOPICS * QUEUE_DEPTH;
    localparam int unsigned AW = $clog2(SLOTS);
    localparam int unsigned EW = 32 + 8 + 32 + 32;

    logic [EW-1:0] r_mem [SLOTS];
    logic [PW-1:0] r_oldest [NUM_TOPICS];
    logic [CW-1:0] r_fill [NUM_TOPICS];
    logic [31:0]   r_next;
    logic [15:0]   r_max_age;

    logic [TW-1:0] r_t;
    logic          r_bad;
    logic [7:0]    r_pub;
    logic [31:0]   r_pay;
    logic [31:0]   r_last;
    logic [31:0]   r_now;
    logic [CW-1:0] r_pos;
    logic [4:0]    r_removed;
    logic [EW-1:0] r_rd;
    logic [31:0]   r_first;

    logic [PW-1:0] oldest;
    logic [CW-1:0] fill;
    logic [CW-1:0] pos;
    logic [AW-1:0] addr;
    logic [PW:0]   ring;
    logic [32:0]   age;

    assign oldest = r_oldest[r_t];
    assign fill   = r_fill[r_t];

    always_comb begin
        pos = r_pos;
        if (i_ctl.cmd == CMD_WRITE) pos = fill;
        else if (i_ctl.read_next && !o_sts.match) pos = '0;
        else if (i_ctl.cmd == CMD_READ && r_pos != '0 && !i_ctl.read_next) pos = r_pos;
        ring = {1'b0, oldest} + {1'b0, PW'(pos)};
        if (ring >= (PW+1)'(QUEUE_DEPTH)) ring = ring - (PW+1)'(QUEUE_DEPTH);
        addr = AW'(r_t) * AW'(QUEUE_DEPTH) + AW'(ring[PW-1:0]);
    end

    assign age = {1'b0, r_now} - {1'b0, r_rd[31:0]};

    always_comb begin
        o_sts.bad       = r_bad;
        o_sts.empty     = (fill == '0);
        o_sts.full      = (fill >= CW'(QUEUE_DEPTH));
        o_sts.last_zero = (r_last == '0);
        o_sts.match     = (r_rd[EW-1 -: 32] == r_last);
        o_sts.at_end    = (r_pos + CW'(1) >= fill);
        o_sts.older     = (r_last < r_first);
        o_sts.aged      = !age[32] && (age[31:0] > {16'd0, r_max_age});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmd == CMD_WRITE)
            r_mem[addr] <= {r_next, r_pub, r_pay, r_now};
        r_rd <= r_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_TOPICS; k++) begin
                r_oldest[k] <= '0;
                r_fill[k]   <= '0;
            end
            r_next    <= 32'd1;
            r_max_age <= '0;
            o_valid   <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) r_max_age <= i_cfg_data;
            unique case (i_ctl.cmd)
                CMD_LOAD: begin
                    r_t       <= TW'(i_topic);
                    r_bad     <= (i_action == ActNone) || (32'(i_topic) >= NUM_TOPICS);
                    r_pub     <= i_publisher_id;
                    r_pay     <= i_payload_handle;
                    r_last    <= i_last_entry;
                    r_now     <= i_now_seconds;
                    r_pos     <= '0;
                    r_removed <= '0;
                end
                CMD_WRITE: begin
                    r_fill[r_t] <= fill + CW'(1);
                    r_next      <= (r_next == '1) ? 32'd1 : r_next + 32'd1;
                    o_valid           <= 1'b1;
                    o_status          <= StOk;
                    o_entry_number    <= r_next;
                    o_entry_publisher <= r_pub;
                    o_entry_payload   <= r_pay;
                    o_entry_stamp     <= r_now;
                    o_removed_count   <= '0;
                end
                CMD_READ: begin
                    if (r_pos == '0 && !i_ctl.read_next) r_first <= r_mem[addr][EW-1 -: 32];
                    if (i_ctl.read_next) r_pos <= o_sts.match ? r_pos + CW'(1) : '0;
                    else if (i_ctl.step) r_pos <= r_pos + CW'(1);
                end
                CMD_POP: begin
                    r_oldest[r_t] <= (oldest == PW'(QUEUE_DEPTH - 1)) ? '0 : oldest + PW'(1);
                    r_fill[r_t]   <= fill - CW'(1);
                    r_removed     <= r_removed + 5'd1;
                end
                CMD_OUT_ENTRY: begin
                    o_valid           <= 1'b1;
                    o_status          <= i_skip ? StSkip : StOk;
                    o_entry_number    <= r_rd[EW-1 -: 32];
                    o_entry_publisher <= r_rd[71:64];
                    o_entry_payload   <= r_rd[63:32];
                    o_entry_stamp     <= r_rd[31:0];
                    o_removed_count   <= '0;
                end
                CMD_OUT_ZERO, CMD_OUT_CLEAN: begin
                    o_valid           <= 1'b1;
                    o_status          <= (i_ctl.cmd == CMD_OUT_CLEAN) ? StOk : StFail;
                    o_entry_number    <= '0;
                    o_entry_publisher <= '0;
                    o_entry_payload   <= '0;
                    o_entry_stamp     <= '0;
                    o_removed_count   <= (i_ctl.cmd == CMD_OUT_CLEAN) ? r_removed : 5'd0;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

### hw/rtl/aged_topic_queue_engine.sv
// one item at a time; each search or pop step costs a memory read and a check
// throughput: the next item is taken at the edge that takes the result
// reset: synchronous active low, queues empty, entry number 1, max age 0
// the receiver cannot stall: each result is shown for one cycle
`default_nettype none
module aged_topic_queue_engine
    import atqe_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
    parameter int unsigned NUM_TOPICS  = NumTopicsDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic [1:0]  i_action,
    input  wire logic [1:0]  i_topic,
    input  wire logic [7:0]  i_publisher_id,
    input  wire logic [31:0] i_payload_handle,
    input  wire logic [31:0] i_last_entry,
    input  wire logic [31:0] i_now_seconds,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [31:0]      o_entry_number,
    output logic [7:0]       o_entry_publisher,
    output logic [31:0]      o_entry_payload,
    output logic [31:0]      o_entry_stamp,
    output logic [4:0]       o_removed_count
);
    t_ctl ctl;
    t_sts sts;
    logic skip;

    atqe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_sts    (sts),
        .o_busy   (busy),
        .o_skip   (skip),
        .o_ctl    (ctl)
    );

    atqe_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .NUM_TOPICS(NUM_TOPICS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .i_skip            (skip),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_action          (i_action),
        .i_topic           (i_topic),
        .i_publisher_id    (i_publisher_id),
        .i_payload_handle  (i_payload_handle),
        .i_last_entry      (i_last_entry),
        .i_now_seconds     (i_now_seconds),
        .o_sts             (sts),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_entry_number    (o_entry_number),
        .o_entry_publisher (o_entry_publisher),
        .o_entry_payload   (o_entry_payload),
        .o_entry_stamp     (o_entry_stamp),
        .o_removed_count   (o_removed_count)
    );
endmodule
`default_nettype wire
